FILE: design/lru_page_replacement_unit_macros.svh
// assertion macros shared by the lru page replacement design
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold at every edge outside reset
`define LRU_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("lru assertion failed");

// consequent must hold in the same cycle as the antecedent
`define LRU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lru assertion failed");

// consequent must hold in the cycle after the antecedent
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lru assertion failed");

`else

`define LRU_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define LRU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/lru_pkg.sv
package lru_pkg;

    // fixed field widths of the request and result
    localparam int PAGE_NUMBER_W = 16;
    localparam int CFG_W         = 4;
    localparam int COUNT_W       = 32;

    localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RST = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 32'hFFFF_FFFF;

    // outcome of one reference, from the frame table to the result register
    typedef struct packed {
        logic                     hit;
        logic                     evicted_valid;
        logic [PAGE_NUMBER_W-1:0] evicted_page;
        logic [CFG_W-1:0]         resident_count;
    } t_frame_resp;

endpackage

FILE: design/lru_frame_table.sv
`include "lru_page_replacement_unit_macros.svh"

module lru_frame_table #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    input  logic [PAGE_BITS-1:0]      i_req_page,
    input  logic [lru_pkg::CFG_W-1:0] i_frames_in_use,
    output lru_pkg::t_frame_resp      o_resp
);

    localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W  = (CNT_W > lru_pkg::CFG_W) ? CNT_W : lru_pkg::CFG_W;

    logic [PAGE_BITS-1:0]  r_page [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;
    logic [RANK_W-1:0]     r_rank [MAX_FRAMES];
    logic [CNT_W-1:0]      r_count;

    logic [MAX_FRAMES-1:0]     n_valid;
    logic [RANK_W-1:0]         n_rank [MAX_FRAMES];
    logic [CNT_W-1:0]          n_count;

    logic [MAX_FRAMES-1:0]     hit_vec;
    logic [MAX_FRAMES-1:0]     free_vec;
    logic [MAX_FRAMES-1:0]     lru_vec;
    logic [MAX_FRAMES-1:0]     slot_vec;
    logic [RANK_W-1:0]         hit_rank;
    logic [RANK_W-1:0]         lru_rank;
    logic [PAGE_BITS-1:0]      evict_page;
    logic [lru_pkg::CFG_W-1:0] limit;
    logic                      hit;
    logic                      full;
    logic                      evict;
    logic                      load;

    // tag compare, free slot search and lru pick, all in parallel
    always_comb begin
        logic free_found;
        free_found = 1'b0;
        lru_rank   = RANK_W'(r_count - CNT_W'(1));
        hit_rank   = '0;
        evict_page = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            hit_vec[i]  = r_valid[i] && (r_page[i] == i_req_page);
            lru_vec[i]  = r_valid[i] && (r_rank[i] == lru_rank);
            free_vec[i] = !r_valid[i] && !free_found;
            free_found  = free_found || !r_valid[i];
            hit_rank    = hit_rank | (hit_vec[i] ? r_rank[i] : '0);
            evict_page  = evict_page | (lru_vec[i] ? r_page[i] : '0);
        end
    end

    // a limit of zero acts as one, above the frame count the table itself caps it
    assign limit    = (i_frames_in_use == '0) ? lru_pkg::CFG_W'(1) : i_frames_in_use;
    assign full     = (CMP_W'(r_count) >= CMP_W'(limit))
                   || (r_count == CNT_W'(MAX_FRAMES));
    assign hit      = |hit_vec;
    assign evict    = !hit && full;
    assign load     = i_req_valid && !hit;
    assign slot_vec = evict ? lru_vec : free_vec;

    always_comb begin
        n_valid = r_valid | (load ? slot_vec : '0);
        n_count = (load && !evict) ? (r_count + CNT_W'(1)) : r_count;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            n_rank[i] = r_rank[i];
            if (i_req_valid) begin
                if (hit) begin
                    if (hit_vec[i]) begin
                        n_rank[i] = '0;
                    end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                        n_rank[i] = r_rank[i] + RANK_W'(1);
                    end
                end else begin
                    if (slot_vec[i]) begin
                        n_rank[i] = '0;
                    end else if (r_valid[i]) begin
                        n_rank[i] = r_rank[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // page tags: only read behind their valid bit
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (load && slot_vec[i]) begin
                r_page[i] <= i_req_page;
            end
        end
    end

    assign o_resp.hit            = hit;
    assign o_resp.evicted_valid  = evict;
    assign o_resp.evicted_page   = evict ? lru_pkg::PAGE_NUMBER_W'(evict_page) : '0;
    assign o_resp.resident_count = lru_pkg::CFG_W'(n_count);

    // resident pages are distinct, so at most one tag matches
    `LRU_ASSERT_ALWAYS(a_single_hit, i_clk, i_rst_n, $onehot0(hit_vec))
    // an eviction always finds exactly one least recent frame
    `LRU_ASSERT_SAME(a_lru_unique, i_clk, i_rst_n, i_req_valid && evict, $onehot(lru_vec))
    // a fill without eviction always has a free frame to go to
    `LRU_ASSERT_SAME(a_free_slot, i_clk, i_rst_n, load && !evict, $onehot(free_vec))
    // the occupancy count tracks the valid bits
    `LRU_ASSERT_ALWAYS(a_count_match, i_clk, i_rst_n,
        $countones(r_valid) == int'(r_count))

endmodule

FILE: design/lru_page_replacement_unit.sv
// lru page replacement unit: one page reference in, one result out
// path: a taken request is held in the request register, looked up in the frame table,
// and its result leaves the result register with o_done high
// throughput: one request every cycle, set by the tag compare and rank update
// the receiver cannot stall, busy is never raised; i_rst_n is synchronous, active low
// reset empties every frame, clears both totals and sets the frame limit to eight
`include "lru_page_replacement_unit_macros.svh"

module lru_page_replacement_unit #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  logic [lru_pkg::PAGE_NUMBER_W-1:0] i_page_number,
    // frame limit register
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lru_pkg::CFG_W-1:0]         i_cfg_data,
    // result channel
    output logic                              o_done,
    output logic                              o_hit,
    output logic                              o_evicted_valid,
    output logic [lru_pkg::PAGE_NUMBER_W-1:0] o_evicted_page,
    output logic [lru_pkg::CFG_W-1:0]         o_resident_count,
    output logic [lru_pkg::COUNT_W-1:0]       o_fault_count,
    output logic [lru_pkg::COUNT_W-1:0]       o_hit_count
);

    // limit register
    logic [lru_pkg::CFG_W-1:0]   r_frames_in_use;
    // request register
    logic                        r_req_valid;
    logic [PAGE_BITS-1:0]        r_req_page;
    // result register
    logic                        r_done;
    lru_pkg::t_frame_resp        r_resp;
    // running totals, saturating
    logic [lru_pkg::COUNT_W-1:0] r_fault_total;
    logic [lru_pkg::COUNT_W-1:0] r_hit_total;
    logic [lru_pkg::COUNT_W-1:0] n_fault_total;
    logic [lru_pkg::COUNT_W-1:0] n_hit_total;

    lru_pkg::t_frame_resp        resp;
    logic                        req_take;

    // every stage moves each cycle, so a request can always be taken
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign req_take    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= lru_pkg::FRAMES_IN_USE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frames_in_use <= i_cfg_data;
        end
    end

    // request register: page number reduced to the stored tag width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= req_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_req_page <= PAGE_BITS'(i_page_number);
        end
    end

    // lookup, lru choice and recency update for the registered request
    lru_frame_table #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_frame_table (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (r_req_valid),
        .i_req_page      (r_req_page),
        .i_frames_in_use (r_frames_in_use),
        .o_resp          (resp)
    );

    // totals move in step with the result register
    always_comb begin
        n_fault_total = r_fault_total;
        n_hit_total   = r_hit_total;
        if (r_req_valid) begin
            if (resp.hit) begin
                if (r_hit_total != lru_pkg::COUNT_MAX) begin
                    n_hit_total = r_hit_total + lru_pkg::COUNT_W'(1);
                end
            end else begin
                if (r_fault_total != lru_pkg::COUNT_MAX) begin
                    n_fault_total = r_fault_total + lru_pkg::COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done        <= 1'b0;
            r_fault_total <= '0;
            r_hit_total   <= '0;
        end else begin
            r_done        <= r_req_valid;
            r_fault_total <= n_fault_total;
            r_hit_total   <= n_hit_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_valid) begin
            r_resp <= resp;
        end
    end

    // the totals are read straight from their registers while the strobe is up
    assign o_done           = r_done;
    assign o_hit            = r_resp.hit;
    assign o_evicted_valid  = r_resp.evicted_valid;
    assign o_evicted_page   = r_resp.evicted_page;
    assign o_resident_count = r_resp.resident_count;
    assign o_fault_count    = r_fault_total;
    assign o_hit_count      = r_hit_total;

    // every registered request raises the result strobe through the result register
    `LRU_ASSERT_NEXT(a_req_to_done, i_clk, i_rst_n, r_req_valid, r_done)
    // the strobe is never raised without a request behind it
    `LRU_ASSERT_NEXT(a_no_spurious_done, i_clk, i_rst_n, !r_req_valid, !r_done)
    // on a hit the hit total advances and the fault total holds, unless the hit total is saturated
    `LRU_ASSERT_NEXT(a_hit_total_step, i_clk, i_rst_n,
        r_req_valid && resp.hit && (r_hit_total != lru_pkg::COUNT_MAX),
        (r_hit_total == $past(r_hit_total) + lru_pkg::COUNT_W'(1))
            && $stable(r_fault_total))
    // an eviction only ever comes with a fault
    `LRU_ASSERT_SAME(a_evict_on_fault, i_clk, i_rst_n,
        o_done && o_evicted_valid, !o_hit)

endmodule
